FILE: rtl/obm_pkg.sv
`timescale 1ns / 1ps

package obm_pkg;

  localparam int NUM_REGS = 8;
  localparam int REG_IDX_W = 3;
  localparam int CFG_VAL_W = 10;

  localparam logic [REG_IDX_W-1:0] REG_RST_LOW   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PRES_WAIT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RST_TAIL  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_W1_LOW    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_WSLOT     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_RD_LOW    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_RD_SAMPLE = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_RD_TAIL   = 3'd7;

  localparam logic [1:0] REQ_RESET = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_LOW  = 4'd1,
    PH_RST_WAIT = 4'd2,
    PH_RST_TAIL = 4'd3,
    PH_W_LOW    = 4'd4,
    PH_W_HIGH   = 4'd5,
    PH_W_REC    = 4'd6,
    PH_R_LOW    = 4'd7,
    PH_R_WAIT   = 4'd8,
    PH_R_TAIL   = 4'd9
  } phase_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;
    logic       rejected;
  } result_t;

  function automatic logic [CFG_VAL_W-1:0] reg_reset_val(input logic [REG_IDX_W-1:0] idx);
    logic [CFG_VAL_W-1:0] v;
    case (idx)
      REG_RST_LOW:   v = 10'd480;
      REG_PRES_WAIT: v = 10'd80;
      REG_RST_TAIL:  v = 10'd400;
      REG_W1_LOW:    v = 10'd1;
      REG_WSLOT:     v = 10'd60;
      REG_RD_LOW:    v = 10'd2;
      REG_RD_SAMPLE: v = 10'd10;
      REG_RD_TAIL:   v = 10'd50;
      default:       v = 10'd1;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/one_wire_bus_master_top.sv
`timescale 1ns / 1ps
// the result word is registered and offered in the cycle after its input word is accepted
// throughput: one word per cycle unless out_ready stalls the output; the output register frees as the result is taken
// bus timing counts tick strobes carried in the input words, not clock cycles
// reset: synchronous active-low rst_n; bus idle, presence and read byte cleared,
// timing registers back to their defaults

module one_wire_bus_master_top
  import obm_pkg::*;
#(
  parameter int TIME_WIDTH = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_tick,
  input  logic        in_line_level,
  input  logic        in_cmd_valid,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_drive_low,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic        out_presence,
  output logic [7:0]  out_read_data,
  output logic        out_rejected
);

  logic [NUM_REGS-1:0][TIME_WIDTH-1:0] timing;
  result_t                             result;

  assign pready = 1'b1;

  obm_regs #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .timing_o (timing)
  );

  obm_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .timing_i      (timing),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_tick       (in_tick),
    .in_line_level (in_line_level),
    .in_cmd_valid  (in_cmd_valid),
    .in_req_type   (in_req_type),
    .in_write_data (in_write_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_o      (result)
  );

  assign out_drive_low = result.drive_low;
  assign out_busy_res  = result.busy_res;
  assign out_done_res  = result.done_res;
  assign out_presence  = result.presence;
  assign out_read_data = result.read_data;
  assign out_rejected  = result.rejected;

endmodule

FILE: rtl/obm_regs.sv
`timescale 1ns / 1ps

module obm_regs
  import obm_pkg::*;
#(
  parameter int TIME_WIDTH = 10
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [4:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic [NUM_REGS-1:0][TIME_WIDTH-1:0]  timing_o
);

  logic [NUM_REGS-1:0][TIME_WIDTH-1:0] timing_r;
  logic [NUM_REGS-1:0][TIME_WIDTH-1:0] timing_nxt;
  logic [REG_IDX_W-1:0]                idx;

  assign idx = paddr[4:2];

  always_comb begin
    timing_nxt = timing_r;
    if (psel && penable && pwrite) begin
      timing_nxt[idx] = TIME_WIDTH'(pwdata[CFG_VAL_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        timing_r[i] <= TIME_WIDTH'(reg_reset_val(REG_IDX_W'(i)));
      end
    end else begin
      timing_r <= timing_nxt;
    end
  end

  assign prdata   = 32'(timing_r[idx]);
  assign timing_o = timing_r;

endmodule

FILE: rtl/obm_core.sv
`timescale 1ns / 1ps

module obm_core
  import obm_pkg::*;
#(
  parameter int TIME_WIDTH = 10
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [NUM_REGS-1:0][TIME_WIDTH-1:0]  timing_i,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_tick,
  input  logic                                 in_line_level,
  input  logic                                 in_cmd_valid,
  input  logic [1:0]                           in_req_type,
  input  logic [7:0]                           in_write_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output result_t                              result_o
);

  phase_t                phase_r, phase_nxt;
  logic [TIME_WIDTH-1:0] tick_count_r, tick_count_nxt;
  logic [2:0]            bit_index_r, bit_index_nxt;
  logic [7:0]            shift_r, shift_nxt;
  logic                  presence_r, presence_nxt;
  logic [7:0]            last_read_r, last_read_nxt;
  logic                  done_nxt, rej_nxt;
  logic                  out_valid_r, out_valid_nxt;
  result_t               result_r, result_nxt;

  logic                  in_fire;
  logic [TIME_WIDTH-1:0] len_raw, len;
  logic [TIME_WIDTH:0]   tc_inc;
  logic                  phase_last;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // current phase length
  always_comb begin
    case (phase_r)
      PH_RST_LOW:  len_raw = timing_i[REG_RST_LOW];
      PH_RST_WAIT: len_raw = timing_i[REG_PRES_WAIT];
      PH_RST_TAIL: len_raw = timing_i[REG_RST_TAIL];
      PH_W_LOW:    len_raw = shift_r[0] ? timing_i[REG_W1_LOW] : timing_i[REG_WSLOT];
      PH_W_HIGH:   len_raw = timing_i[REG_WSLOT];
      PH_R_LOW:    len_raw = timing_i[REG_RD_LOW];
      PH_R_WAIT:   len_raw = timing_i[REG_RD_SAMPLE];
      PH_R_TAIL:   len_raw = timing_i[REG_RD_TAIL];
      default:     len_raw = TIME_WIDTH'(1);
    endcase
    len        = (len_raw == '0) ? TIME_WIDTH'(1) : len_raw;
    tc_inc     = {1'b0, tick_count_r} + (TIME_WIDTH+1)'(1);
    phase_last = (tc_inc >= {1'b0, len});
  end

  // next state
  always_comb begin
    phase_nxt      = phase_r;
    tick_count_nxt = tick_count_r;
    bit_index_nxt  = bit_index_r;
    shift_nxt      = shift_r;
    presence_nxt   = presence_r;
    last_read_nxt  = last_read_r;
    done_nxt       = 1'b0;
    rej_nxt        = 1'b0;
    if (in_fire) begin
      if (phase_r == PH_IDLE) begin
        if (in_cmd_valid) begin
          case (in_req_type)
            REQ_RESET: begin
              bit_index_nxt  = '0;
              tick_count_nxt = '0;
              phase_nxt      = PH_RST_LOW;
            end
            REQ_WRITE: begin
              bit_index_nxt  = '0;
              tick_count_nxt = '0;
              shift_nxt      = in_write_data;
              phase_nxt      = PH_W_LOW;
            end
            REQ_READ: begin
              bit_index_nxt  = '0;
              tick_count_nxt = '0;
              shift_nxt      = '0;
              phase_nxt      = PH_R_LOW;
            end
            default: ;
          endcase
        end
      end else begin
        rej_nxt = in_cmd_valid;
        if (in_tick) begin
          if (phase_last) begin
            tick_count_nxt = '0;
            case (phase_r)
              PH_RST_LOW:  phase_nxt = PH_RST_WAIT;
              PH_RST_WAIT: begin
                presence_nxt = !in_line_level;
                phase_nxt    = PH_RST_TAIL;
              end
              PH_RST_TAIL: begin
                phase_nxt = PH_IDLE;
                done_nxt  = 1'b1;
              end
              PH_W_LOW:    phase_nxt = shift_r[0] ? PH_W_HIGH : PH_W_REC;
              PH_W_HIGH, PH_W_REC: begin
                shift_nxt = {1'b0, shift_r[7:1]};
                if (bit_index_r == 3'd7) begin
                  bit_index_nxt = '0;
                  phase_nxt     = PH_IDLE;
                  done_nxt      = 1'b1;
                end else begin
                  bit_index_nxt = bit_index_r + 3'd1;
                  phase_nxt     = PH_W_LOW;
                end
              end
              PH_R_LOW:    phase_nxt = PH_R_WAIT;
              PH_R_WAIT: begin
                shift_nxt = {in_line_level, shift_r[7:1]};
                phase_nxt = PH_R_TAIL;
              end
              PH_R_TAIL: begin
                if (bit_index_r == 3'd7) begin
                  bit_index_nxt = '0;
                  last_read_nxt = shift_r;
                  phase_nxt     = PH_IDLE;
                  done_nxt      = 1'b1;
                end else begin
                  bit_index_nxt = bit_index_r + 3'd1;
                  phase_nxt     = PH_R_LOW;
                end
              end
              default:     phase_nxt = PH_IDLE;
            endcase
          end else begin
            tick_count_nxt = tc_inc[TIME_WIDTH-1:0];
          end
        end
      end
    end
  end

  // result word
  always_comb begin
    result_nxt.drive_low = (phase_nxt inside {PH_RST_LOW, PH_W_LOW, PH_R_LOW});
    result_nxt.busy_res  = (phase_nxt != PH_IDLE);
    result_nxt.done_res  = done_nxt;
    result_nxt.presence  = presence_nxt;
    result_nxt.read_data = last_read_nxt;
    result_nxt.rejected  = rej_nxt;
    out_valid_nxt        = in_fire || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      tick_count_r <= '0;
      bit_index_r  <= '0;
      shift_r      <= '0;
      presence_r   <= 1'b0;
      last_read_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      tick_count_r <= tick_count_nxt;
      bit_index_r  <= bit_index_nxt;
      shift_r      <= shift_nxt;
      presence_r   <= presence_nxt;
      last_read_r  <= last_read_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign result_o  = result_r;

endmodule

FILE: rtl/obm_checker.sv
`timescale 1ns / 1ps

module obm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_drive_low,
  input logic       out_busy_res,
  input logic       out_done_res,
  input logic       out_presence,
  input logic [7:0] out_read_data,
  input logic       out_rejected
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word present after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({out_drive_low, out_busy_res,
      out_done_res, out_presence, out_read_data, out_rejected}))
    else $error("stalled result word changed");

  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled while output register free");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res)
    else $error("done reported while still busy");

  a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_drive_low |-> out_busy_res)
    else $error("line driven low while idle");

endmodule

bind one_wire_bus_master_top obm_checker u_obm_checker (.*);
